@@ src/assert_macros.svh @@
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define AST_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define AST_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/psc_pkg.sv @@
// Package with types and constants of the pileup SNP caller.
`default_nettype none
package psc_pkg;
  localparam int TableDepth = 65536;
  localparam int IdxW = $clog2(TableDepth);
  localparam logic [1:0] OP_BASE  = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_DEL   = 2'd2;
  localparam logic [1:0] OP_DRAIN = 2'd3;
  localparam logic [2:0] REG_MINQ = 3'd0;
  localparam logic [2:0] REG_MIND = 3'd1;
  localparam logic [2:0] REG_PCT  = 3'd2;
  localparam logic [2:0] REG_CNT  = 3'd3;
  localparam logic [2:0] REG_SR   = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] position;
    logic [3:0]  base_code;
    logic [2:0]  ref_base;
    logic [7:0]  quality;
    logic        reverse_strand;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  call_code;
    logic [1:0]  alt_base;
    logic [7:0]  mean_quality;
    logic [31:0] total_depth;
    logic [31:0] count_a;
    logic [31:0] count_c;
    logic [31:0] count_g;
    logic [31:0] count_t;
    logic [15:0] fwd_alt;
    logic [15:0] rev_alt;
    logic [15:0] fwd_total;
    logic [15:0] rev_total;
  } out_item_t;

  // One table entry: counts, depth, qsum and strand counters.
  typedef struct packed {
    logic [31:0] ca, cc, cg, ct, dep, qsum;
    logic [15:0] fa, ra, ft, rt;
  } entry_t;
endpackage
`default_nettype wire

@@ src/pileup_snp_caller.sv @@
// Top level of the pileup SNP caller: table memory, update and drain logic.
//
// Sequencing: a base, match or deletion transaction reads the memory when it
// is accepted, then modifies and writes back the entry in ST_UPD, with busy
// high. A drain keeps busy high after it is accepted: the alternate is picked
// and the entry cleared, a radix-2 divider produces the mean quality one
// quotient bit per cycle, then the filter states ST_F1 and ST_F2 follow. The
// result appears on out_valid for exactly one cycle right after busy falls,
// and cannot be stalled; a new transaction can be accepted at the edge that
// ends that cycle.
// After reset a clearing pass writes zero to all 65536 entries, one per cycle,
// with busy high; configuration writes are accepted throughout.
`default_nettype none
module pileup_snp_caller import psc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_UPD = 3'd2,
                         ST_DIV = 3'd3, ST_F1 = 3'd4, ST_F2 = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [IdxW-1:0] clr_r;
  logic [7:0]  minq_r;
  logic [15:0] mind_r, cnt_r;
  logic [6:0]  pct_r;
  logic [8:0]  sr_r;

  entry_t mem [TableDepth];
  entry_t rd_r;
  in_item_t it_r;
  logic [IdxW-1:0] idx;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t wr_data;

  // divider
  logic [31:0] dq_r, dr_r, ddiv_r;
  logic [5:0]  dcnt_r;
  logic [33:0] dtrial;
  logic [32:0] dr_sh;

  // alternate choice
  logic [31:0] c [4];
  logic [1:0] alt_r;
  logic [31:0] alt_cnt_r, ref_cnt;
  logic [1:0] ax, ay, az, alt_c;
  logic [31:0] alt_cnt_c;
  logic f_pct_r, f_hom_r, f_str_r;
  logic [15:0] num, den;

  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  wire acc = start && !busy;
  wire ref_ok = it_r.ref_base < 3'd4;

  assign cfg_pready = 1'b1;
  assign idx = in_item.position[IdxW-1:0];

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_MINQ: cfg_prdata = {24'd0, minq_r};
      REG_MIND: cfg_prdata = {16'd0, mind_r};
      REG_PCT:  cfg_prdata = {25'd0, pct_r};
      REG_CNT:  cfg_prdata = {16'd0, cnt_r};
      REG_SR:   cfg_prdata = {23'd0, sr_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minq_r <= 8'd20; mind_r <= 16'd1; pct_r <= 7'd20; cnt_r <= 16'd1;
      sr_r <= 9'd26;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_MINQ: minq_r <= cfg_pwdata[7:0];
        REG_MIND: mind_r <= cfg_pwdata[15:0];
        REG_PCT:  pct_r  <= cfg_pwdata[6:0];
        REG_CNT:  cnt_r  <= cfg_pwdata[15:0];
        REG_SR:   sr_r   <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) rd_r <= mem[idx];
    if (wr_en) mem[wr_idx] <= wr_data;
  end

  assign c[0] = rd_r.ca; assign c[1] = rd_r.cc;
  assign c[2] = rd_r.cg; assign c[3] = rd_r.ct;

  // Memory write data: clearing pass, read-modify-write and drain clear.
  logic isb;
  logic [1:0] b;
  logic mis;
  always_comb begin
    isb = 1'b1; b = 2'd0;
    case (it_r.base_code)
      4'd1: b = 2'd0;
      4'd2: b = 2'd1;
      4'd4: b = 2'd2;
      4'd8: b = 2'd3;
      default: isb = 1'b0;
    endcase
    mis = !ref_ok || (b != it_r.ref_base[1:0]);
    wr_data = rd_r;
    wr_en = 1'b0;
    wr_idx = it_r.position[IdxW-1:0];
    if (st_r == ST_CLR) begin
      wr_en = 1'b1; wr_idx = clr_r; wr_data = '0;
    end else if (st_r == ST_UPD) begin
      wr_en = 1'b1;
      if (it_r.quality != 8'd0 &&
          (it_r.op != OP_BASE || isb)) wr_data.dep = rd_r.dep + 32'd1;
      if (isb && it_r.op != OP_DEL) begin
        if (it_r.quality != 8'd0) begin
          case (b)
            2'd0: wr_data.ca = rd_r.ca + 32'd1;
            2'd1: wr_data.cc = rd_r.cc + 32'd1;
            2'd2: wr_data.cg = rd_r.cg + 32'd1;
            default: wr_data.ct = rd_r.ct + 32'd1;
          endcase
        end
        if (it_r.reverse_strand) wr_data.rt = rd_r.rt + 16'd1;
        else wr_data.ft = rd_r.ft + 16'd1;
        if (mis) begin
          wr_data.qsum = rd_r.qsum + {24'd0, it_r.quality};
          if (it_r.reverse_strand) wr_data.ra = rd_r.ra + 16'd1;
          else wr_data.fa = rd_r.fa + 16'd1;
        end
      end
    end else if (st_r == ST_DIV && dcnt_r == 6'd0) begin
      wr_en = 1'b1; wr_data = '0;
    end
  end

  always_comb begin
    ax = 2'd0; ay = 2'd1; az = 2'd2;
    case (it_r.ref_base[1:0])
      2'd0: begin ax = 2'd1; ay = 2'd2; az = 2'd3; end
      2'd1: begin ax = 2'd0; ay = 2'd2; az = 2'd3; end
      2'd2: begin ax = 2'd0; ay = 2'd1; az = 2'd3; end
      default: ;
    endcase
    ref_cnt = ref_ok ? c[it_r.ref_base[1:0]] : 32'd0;
    if (c[ax] > c[ay]) begin alt_c = ax; alt_cnt_c = c[ax]; end
    else begin alt_c = ay; alt_cnt_c = c[ay]; end
    if (c[az] > alt_cnt_c) begin alt_c = az; alt_cnt_c = c[az]; end
    if (!ref_ok) begin alt_c = 2'd0; alt_cnt_c = 32'd0; end
    // keep the carry bit so divisors above 2^31 work
    dr_sh = {dr_r, dq_r[31]};
    dtrial = {1'b0, dr_sh} - {2'b0, ddiv_r};
    if (rd_r.fa < rd_r.ra) begin num = rd_r.fa; den = rd_r.ra; end
    else begin num = rd_r.ra; den = rd_r.fa; end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_r == IdxW'(TableDepth - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (acc) st_nxt = in_item.op == OP_DRAIN ? ST_DIV : ST_UPD;
      ST_UPD:  st_nxt = ST_IDLE;
      ST_DIV:  if (dcnt_r == 6'd32) st_nxt = ST_F1;
      ST_F1:   st_nxt = ST_F2;
      ST_F2:   st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy = st_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; clr_r <= '0; out_valid <= 1'b0; dcnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid <= st_r == ST_F2;
      if (st_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (acc) dcnt_r <= '0;
      else if (st_r == ST_DIV) dcnt_r <= dcnt_r + 6'd1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) it_r <= in_item;
    if (st_r == ST_DIV) begin
      if (dcnt_r == 6'd0) begin
        alt_r <= alt_c; alt_cnt_r <= alt_cnt_c;
        ddiv_r <= rd_r.dep - ref_cnt;
        dq_r <= rd_r.qsum; dr_r <= '0;
      end else if (dcnt_r <= 6'd32) begin
        if (!dtrial[33]) begin dr_r <= dtrial[31:0]; dq_r <= {dq_r[30:0], 1'b1}; end
        else begin dr_r <= dr_sh[31:0]; dq_r <= {dq_r[30:0], 1'b0}; end
      end
    end
    if (st_r == ST_F1) begin
      f_pct_r <= {7'd0, alt_cnt_r} * 39'd100 > {32'd0, pct_r} * {7'd0, rd_r.dep}
                 && alt_cnt_r > {16'd0, cnt_r} && rd_r.dep > {16'd0, mind_r}
                 && ref_ok;
      f_hom_r <= {7'd0, alt_cnt_r} * 39'd100 > {7'd0, rd_r.dep} * 39'd80;
      f_str_r <= den != 16'd0 &&
                 ({num, 8'd0} > {15'd0, sr_r} * {8'd0, den} ||
                  (num == 16'd0 && (rd_r.ft == 16'd0 || rd_r.rt == 16'd0)));
    end
    if (st_r == ST_F2) begin
      out_item.alt_base <= alt_r;
      out_item.mean_quality <= ddiv_r == 32'd0 ? 8'd0 :
                               (dq_r > 32'd255 ? 8'd255 : dq_r[7:0]);
      out_item.call_code <= (f_pct_r && f_str_r && ddiv_r != 32'd0 ?
                             dq_r >= {24'd0, minq_r} : minq_r == 8'd0) && f_pct_r
                            && f_str_r ? (f_hom_r ? 2'd2 : 2'd1) : 2'd0;
      out_item.total_depth <= rd_r.dep;
      out_item.count_a <= rd_r.ca; out_item.count_c <= rd_r.cc;
      out_item.count_g <= rd_r.cg; out_item.count_t <= rd_r.ct;
      out_item.fwd_alt <= rd_r.fa; out_item.rev_alt <= rd_r.ra;
      out_item.fwd_total <= rd_r.ft; out_item.rev_total <= rd_r.rt;
    end
  end
endmodule
`default_nettype wire

@@ src/psc_checker.sv @@
// Port-level checker for the pileup SNP caller, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module psc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic cfg_pready
);
  `AST_IMP(a_rdy, clk, rst_n, 1'b1, cfg_pready)
  `AST_NXT(a_acc_busy, clk, rst_n, start && !busy, busy)
  `AST_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  `AST_IMP(a_out_busy, clk, rst_n, out_valid, !$past(out_valid))
endmodule
bind pileup_snp_caller psc_checker u_chk (.clk(clk), .rst_n(rst_n), .start(start),
  .busy(busy), .out_valid(out_valid), .cfg_pready(cfg_pready));
`default_nettype wire

@@ sim/tb_pileup_snp_caller.sv @@
// Testbench for the pileup SNP caller: directed and random transactions checked against a predictor.
module tb_pileup_snp_caller;
  import psc_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int DrainLatency = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pileup_snp_caller u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  entry_t pileup [int];
  logic [7:0] thr_minq = 8'd20;
  logic [15:0] thr_mind = 16'd1;
  logic [6:0] thr_pct = 7'd20;
  logic [15:0] thr_cnt = 16'd1;
  logic [8:0] thr_sr = 9'd26;

  out_item_t calls_pending [$];
  int errors = 0;
  int idle_pct = 0;
  int watchdog = 0;
  logic [2:0] slot_ref [8];
  logic [31:0] slot_pos [8];

  function automatic int base_slot(logic [3:0] code);
    case (code)
      4'd1: return 0;
      4'd2: return 1;
      4'd4: return 2;
      4'd8: return 3;
      default: return -1;
    endcase
  endfunction

  function automatic out_item_t call_site(entry_t e, logic [2:0] refb);
    logic [31:0] c [4];
    logic [31:0] ref_cnt, alt_cnt, divisor, mean, num, den;
    logic [1:0] alt;
    int r, x, y, z;
    bit pass, strand_ok;
    out_item_t o;
    c[0] = e.ca; c[1] = e.cc; c[2] = e.cg; c[3] = e.ct;
    r = (refb > 3'd4) ? 4 : int'(refb);
    ref_cnt = '0; alt_cnt = '0; alt = '0; mean = '0;
    o = '0;
    if (r < 4) begin
      ref_cnt = c[r];
      x = (r == 0) ? 1 : 0;
      y = (r <= 1) ? 2 : 1;
      z = (r == 3) ? 2 : 3;
      // second candidate wins a tie, third must be strictly greater
      if (c[x] > c[y]) begin
        alt = 2'(x); alt_cnt = c[x];
      end else begin
        alt = 2'(y); alt_cnt = c[y];
      end
      if (c[z] > alt_cnt) begin
        alt = 2'(z); alt_cnt = c[z];
      end
    end
    divisor = e.dep - ref_cnt;
    if (divisor != 0) mean = e.qsum / divisor;
    pass = r < 4 && 64'(alt_cnt) * 100 > 64'(thr_pct) * 64'(e.dep)
      && alt_cnt > 32'(thr_cnt) && e.dep > 32'(thr_mind);
    if (pass) begin
      if (e.fa < e.ra) begin
        num = 32'(e.fa); den = 32'(e.ra);
      end else begin
        num = 32'(e.ra); den = 32'(e.fa);
      end
      strand_ok = 0;
      if (den != 0) begin
        if (64'(num) * 256 > 64'(thr_sr) * 64'(den)) strand_ok = 1;
        else if (num == 0 && (e.ft == 0 || e.rt == 0)) strand_ok = 1;
      end
      if (strand_ok && mean >= 32'(thr_minq))
        o.call_code = (64'(alt_cnt) * 100 > 64'(e.dep) * 80) ? 2'd2 : 2'd1;
    end
    o.alt_base = alt;
    o.mean_quality = (mean > 255) ? 8'd255 : mean[7:0];
    o.total_depth = e.dep;
    o.count_a = e.ca; o.count_c = e.cc; o.count_g = e.cg; o.count_t = e.ct;
    o.fwd_alt = e.fa; o.rev_alt = e.ra; o.fwd_total = e.ft; o.rev_total = e.rt;
    return o;
  endfunction

  function automatic void apply_item(in_item_t it);
    int idx, b;
    entry_t e;
    logic [2:0] r;
    idx = int'(it.position % TableDepth);
    e = pileup.exists(idx) ? pileup[idx] : '0;
    b = base_slot(it.base_code);
    r = (it.ref_base > 3'd4) ? 3'd4 : it.ref_base;
    if (it.op == OP_DRAIN) begin
      calls_pending.push_back(call_site(e, it.ref_base));
      pileup.delete(idx);
      return;
    end
    if (it.quality != 0 && (it.op != OP_BASE || b >= 0)) e.dep++;
    if (it.op != OP_DEL && b >= 0) begin
      if (it.quality != 0) begin
        case (b)
          0: e.ca++;
          1: e.cc++;
          2: e.cg++;
          default: e.ct++;
        endcase
      end
      if (it.reverse_strand) e.rt++; else e.ft++;
      if (b != int'(r)) begin
        e.qsum += 32'(it.quality);
        if (it.reverse_strand) e.ra++; else e.fa++;
      end
    end
    pileup[idx] = e;
  endfunction

  // Leave start high; it is lowered here for a random idle gap, or by wait_drained.
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (busy);
    @(posedge clk);
    apply_item(it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [1:0] op, logic [31:0] pos, logic [3:0] code,
                             logic [2:0] refb, logic [7:0] q, logic rev);
    in_item_t it;
    it.op = op; it.position = pos; it.base_code = code;
    it.ref_base = refb; it.quality = q; it.reverse_strand = rev;
    send_item(it);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (calls_pending.size() != 0) @(posedge clk);
    repeat (DrainLatency) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] regi, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {regi, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (regi)
      REG_MINQ: thr_minq = val[7:0];
      REG_MIND: thr_mind = val[15:0];
      REG_PCT:  thr_pct = val[6:0];
      REG_CNT:  thr_cnt = val[15:0];
      REG_SR:   thr_sr = val[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_thresholds(logic [7:0] q, logic [15:0] d, logic [6:0] p,
                                logic [15:0] c, logic [8:0] s);
    wait_drained();
    cfg_write(REG_MINQ, 32'(q));
    cfg_write(REG_MIND, 32'(d));
    cfg_write(REG_PCT, 32'(p));
    cfg_write(REG_CNT, 32'(c));
    cfg_write(REG_SR, 32'(s));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    // empty entry: zero divisor, no strand mismatches
    send_fields(OP_DRAIN, 32'd7, 4'd0, 3'd0, 8'd0, 1'b0);
    // tie: C and G equal, G wins; T equal too, G stays
    for (int i = 0; i < 2; i++) begin
      send_fields(OP_BASE, 32'd100, 4'd2, 3'd0, 8'd255, 1'b0);
      send_fields(OP_BASE, 32'd100, 4'd4, 3'd0, 8'd255, 1'b0);
      send_fields(OP_MATCH, 32'd100, 4'd8, 3'd0, 8'd255, 1'b1);
    end
    send_fields(OP_DRAIN, 32'hFFFF_0064, 4'd0, 3'd0, 8'd0, 1'b0);
    // heterozygous, forward only: ratio zero with no reverse total
    repeat (3) send_fields(OP_BASE, 32'hFFFF_FFFF, 4'd8, 3'd2, 8'd40, 1'b0);
    send_fields(OP_MATCH, 32'hFFFF_FFFF, 4'd15, 3'd2, 8'd0, 1'b1);
    send_fields(OP_DEL, 32'hFFFF_FFFF, 4'd0, 3'd7, 8'd1, 1'b1);
    send_fields(OP_DRAIN, 32'hFFFF_FFFF, 4'd0, 3'd2, 8'd0, 1'b0);
    // other reference never calls
    send_fields(OP_BASE, 32'd0, 4'd1, 3'd4, 8'd128, 1'b1);
    send_fields(OP_BASE, 32'd0, 4'd1, 3'd5, 8'd127, 1'b0);
    send_fields(OP_DRAIN, 32'd0, 4'd0, 3'd6, 8'd0, 1'b0);
    // ambiguous bundled bases and a zero-quality deletion change nothing
    send_fields(OP_BASE, 32'd3, 4'd3, 3'd1, 8'd200, 1'b0);
    send_fields(OP_DEL, 32'd3, 4'd0, 3'd1, 8'd0, 1'b0);
    send_fields(OP_DRAIN, 32'd3, 4'd0, 3'd1, 8'd0, 1'b0);
  endtask

  task automatic test_random(int n, int idle);
    in_item_t it;
    int s;
    idle_pct = idle;
    for (int i = 0; i < 8; i++) begin
      slot_ref[i] = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4))
                                             : 3'($urandom_range(3));
      slot_pos[i] = $urandom;
    end
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(7);
      it.position = (slot_pos[s] & 32'h0000_FFFF) | ($urandom & 32'hFFFF_0000);
      it.ref_base = ($urandom_range(19) == 0) ? 3'($urandom) : slot_ref[s];
      it.reverse_strand = 1'($urandom_range(1));
      it.quality = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      case ($urandom_range(19))
        0, 1: it.op = OP_DRAIN;
        2: it.op = OP_DEL;
        3, 4, 5: it.op = OP_MATCH;
        default: it.op = OP_BASE;
      endcase
      // mostly real bases, favoring one alternate per slot
      case ($urandom_range(9))
        0: it.base_code = 4'($urandom);
        1, 2, 3: it.base_code = 4'd1 << (s % 4);
        default: it.base_code = 4'd1 << $urandom_range(3);
      endcase
      if (it.op == OP_DRAIN) slot_ref[s] = ($urandom_range(9) == 0)
        ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
      send_item(it);
      if (i == n / 2 && idle == 65) wait_drained();
    end
  endtask

  task automatic test_thresholds();
    set_thresholds(8'd0, 16'd0, 7'd0, 16'd0, 9'd0);
    test_random(150, 0);
    set_thresholds(8'd255, 16'd65535, 7'd100, 16'd65535, 9'd256);
    test_random(60, 9);
    set_thresholds(8'd10, 16'd2, 7'd30, 16'd1, 9'd256);
    test_random(150, 65);
    set_thresholds(8'($urandom), 16'($urandom_range(4)), 7'($urandom_range(100)),
                   16'($urandom_range(3)), 9'($urandom_range(256)));
    test_random(150, 9);
  endtask

  always @(negedge clk) begin
    if (out_valid) begin
      if (calls_pending.size() == 0) begin
        $display("%0t: unexpected call %p", $time, out_item);
        errors++;
      end else begin
        out_item_t exp_call;
        exp_call = calls_pending.pop_front();
        if (out_item !== exp_call) begin
          $display("%0t: call mismatch expected %p actual %p", $time, exp_call, out_item);
          errors++;
        end
      end
    end
    if (!rst_n || (start && !busy) || out_valid || cfg_psel) watchdog = 0;
    else watchdog++;
    if (watchdog > WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200, 0);
    test_thresholds();
    wait_drained();
    if (errors == 0 && calls_pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
